// File: rtl/core/obbt_pkg.sv
package obbt_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int ANGLE_BITS  = 16;
	localparam int HALF_WIDTH  = COORD_WIDTH - 1;
	// corner coordinate: center plus rotated offset, two growth bits
	localparam int CORNER_WIDTH = COORD_WIDTH + 2;
	// projection: corner times Q1.15 axis term, summed
	localparam int PROJ_WIDTH = CORNER_WIDTH + 17 + 1;
	localparam int TRIG_WIDTH = 17;

	typedef logic signed [TRIG_WIDTH-1:0]   trig_t;
	typedef logic signed [CORNER_WIDTH-1:0] corner_t;
	typedef logic signed [PROJ_WIDTH-1:0]   proj_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic [HALF_WIDTH-1:0]         w;
		logic [HALF_WIDTH-1:0]         h;
	} rect_in_t;

	typedef struct packed {
		corner_t [3:0] x;
		corner_t [3:0] y;
		trig_t         c;
		trig_t         s;
		logic          has_w;
		logic          has_h;
	} rect_t;

	// rounds a Q.8 x Q1.15 sum to Q.8, half up (floor of (v + 2^14) / 2^15)
	function automatic corner_t round_q15(input logic signed [COORD_WIDTH+18:0] v);
		logic signed [COORD_WIDTH+18:0] t;
		begin
			t = v + (COORD_WIDTH+19)'(16384);
			round_q15 = CORNER_WIDTH'(t >>> 15);
		end
	endfunction

endpackage

// File: rtl/core/obbt_sincos.sv
module obbt_sincos
	import obbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output trig_t                 sin_o,
	output trig_t                 cos_o
);

	logic [31:0] phase;
	logic [1:0]  quad;
	logic [15:0] xp, xq;

	assign phase = {angle, (32-ANGLE_BITS)'(0)};
	assign quad  = phase[31:30];
	assign xp    = {1'b0, phase[29:15]};
	assign xq    = 16'd32768 - xp;

	// stage 1: x2
	logic [15:0] xp_s1, xq_s1, x2p_s1, x2q_s1;
	logic [1:0]  quad_s1;
	logic [31:0] sqp, sqq;
	assign sqp = xp * xp;
	assign sqq = xq * xq;
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s1 <= xp; xq_s1 <= xq; quad_s1 <= quad;
			x2p_s1 <= sqp[30:15]; x2q_s1 <= sqq[30:15];
		end
	end

	// stage 2: t = 21024 - (2320*x2 >> 15)
	logic [15:0] xp_s2, xq_s2, x2p_s2, x2q_s2, tp_s2, tq_s2;
	logic [1:0]  quad_s2;
	logic [27:0] mp2, mq2;
	assign mp2 = 28'd2320 * 28'(x2p_s1);
	assign mq2 = 28'd2320 * 28'(x2q_s1);
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2 <= xp_s1; xq_s2 <= xq_s1; quad_s2 <= quad_s1;
			x2p_s2 <= x2p_s1; x2q_s2 <= x2q_s1;
			tp_s2 <= 16'd21024 - 16'(mp2 >> 15);
			tq_s2 <= 16'd21024 - 16'(mq2 >> 15);
		end
	end

	// stage 3: t = 51472 - (t*x2 >> 15)
	logic [15:0] xp_s3, xq_s3, tp_s3, tq_s3;
	logic [1:0]  quad_s3;
	logic [31:0] mp3, mq3;
	assign mp3 = tp_s2 * x2p_s2;
	assign mq3 = tq_s2 * x2q_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s3 <= xp_s2; xq_s3 <= xq_s2; quad_s3 <= quad_s2;
			tp_s3 <= 16'd51472 - 16'(mp3 >> 15);
			tq_s3 <= 16'd51472 - 16'(mq3 >> 15);
		end
	end

	// stage 4: S = x*t >> 15, saturate, quadrant fold
	logic [31:0] mp4, mq4;
	logic [16:0] sp, sq;
	trig_t       p, q;
	assign mp4 = xp_s3 * tp_s3;
	assign mq4 = xq_s3 * tq_s3;
	assign sp  = mp4[31:15];
	assign sq  = mq4[31:15];
	assign p   = (sp > 17'd32767) ? trig_t'(32767) : trig_t'(sp);
	assign q   = (sq > 17'd32767) ? trig_t'(32767) : trig_t'(sq);
	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s3)
				2'd0: begin sin_o <= p;  cos_o <= q;  end
				2'd1: begin sin_o <= q;  cos_o <= -p; end
				2'd2: begin sin_o <= -p; cos_o <= -q; end
				default: begin sin_o <= -q; cos_o <= p; end
			endcase
		end
	end

endmodule

// File: rtl/core/obbt_corners.sv
module obbt_corners
	import obbt_pkg::*;
(
	input  logic     clk,
	input  logic     en,
	input  rect_in_t rin,
	input  trig_t    s,
	input  trig_t    c,
	output rect_t    rout
);

	localparam int PW = COORD_WIDTH + 19;
	typedef logic signed [PW-1:0] prod_t;

	logic signed [COORD_WIDTH:0] w, h;
	assign w = {2'b0, rin.w};
	assign h = {2'b0, rin.h};

	// stage 1: four products
	prod_t wc_s1, ws_s1, hc_s1, hs_s1;
	rect_in_t r_s1;
	trig_t c_s1, s_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			wc_s1 <= prod_t'(w) * c; ws_s1 <= prod_t'(w) * s;
			hc_s1 <= prod_t'(h) * c; hs_s1 <= prod_t'(h) * s;
			r_s1 <= rin; c_s1 <= c; s_s1 <= s;
		end
	end

	// stage 2: signed sums, round, translate
	logic [3:0] sxn, syn;
	assign sxn = 4'b1001;
	assign syn = 4'b0011;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				rout.x[i] <= CORNER_WIDTH'(r_s1.cx) + round_q15(
					(sxn[i] ? -wc_s1 : wc_s1) - (syn[i] ? -hs_s1 : hs_s1));
				rout.y[i] <= CORNER_WIDTH'(r_s1.cy) + round_q15(
					(sxn[i] ? -ws_s1 : ws_s1) + (syn[i] ? -hc_s1 : hc_s1));
			end
			rout.c <= c_s1; rout.s <= s_s1;
			rout.has_w <= (r_s1.w != '0);
			rout.has_h <= (r_s1.h != '0);
		end
	end

endmodule

// File: rtl/core/obbt_sat.sv
module obbt_sat
	import obbt_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  rect_t ra,
	input  rect_t rb,
	output logic  hit
);

	// axes: 0 A width, 1 A height, 2 B width, 3 B height
	trig_t ax [4], ay [4];
	logic  use_ax [4];
	always_comb begin
		ax[0] = ra.c;  ay[0] = ra.s;  use_ax[0] = ra.has_w;
		ax[1] = -ra.s; ay[1] = ra.c;  use_ax[1] = ra.has_h;
		ax[2] = rb.c;  ay[2] = rb.s;  use_ax[2] = rb.has_w;
		ax[3] = -rb.s; ay[3] = rb.c;  use_ax[3] = rb.has_h;
	end

	// stage 1: 32 projections
	proj_t pa_s1 [4][4], pb_s1 [4][4];
	logic  use_s1 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				use_s1[k] <= use_ax[k];
				for (int i = 0; i < 4; i++) begin
					pa_s1[k][i] <= proj_t'($signed(ra.x[i])) * ax[k]
						+ proj_t'($signed(ra.y[i])) * ay[k];
					pb_s1[k][i] <= proj_t'($signed(rb.x[i])) * ax[k]
						+ proj_t'($signed(rb.y[i])) * ay[k];
				end
			end
		end
	end

	// stage 2: interval ends
	proj_t alo_s2 [4], ahi_s2 [4], blo_s2 [4], bhi_s2 [4];
	logic  use_s2 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				proj_t al, ah, bl, bh;
				al = pa_s1[k][0]; ah = al; bl = pb_s1[k][0]; bh = bl;
				for (int i = 1; i < 4; i++) begin
					if (pa_s1[k][i] < al) al = pa_s1[k][i];
					if (pa_s1[k][i] > ah) ah = pa_s1[k][i];
					if (pb_s1[k][i] < bl) bl = pb_s1[k][i];
					if (pb_s1[k][i] > bh) bh = pb_s1[k][i];
				end
				alo_s2[k] <= al; ahi_s2[k] <= ah; blo_s2[k] <= bl; bhi_s2[k] <= bh;
				use_s2[k] <= use_s1[k];
			end
		end
	end

	// stage 3: overlap decision
	logic [3:0] sep;
	always_comb begin
		for (int k = 0; k < 4; k++)
			sep[k] = use_s2[k] && ((ahi_s2[k] < blo_s2[k]) || (bhi_s2[k] < alo_s2[k]));
	end
	always_ff @(posedge clk) begin
		if (en)
			hit <= (sep == 4'b0);
	end

endmodule

// File: rtl/core/obb_obb_overlap_test.sv
// Pipeline: 4 trig, 2 corner, 3 SAT stages and 1 output register between input
// transaction and result.
// Throughput: one transaction per cycle; a stall freezes the whole pipeline,
// with the last stage decoupled so input is taken while a result waits.
// Reset: arst_n asynchronously clears all valid bits; data registers are not reset.
module obb_obb_overlap_test
	import obbt_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] center_a_x,
	input  logic signed [COORD_WIDTH-1:0] center_a_y,
	input  logic [HALF_WIDTH-1:0]         half_width_a,
	input  logic [HALF_WIDTH-1:0]         half_height_a,
	input  logic [ANGLE_BITS-1:0]         angle_a,
	input  logic signed [COORD_WIDTH-1:0] center_b_x,
	input  logic signed [COORD_WIDTH-1:0] center_b_y,
	input  logic [HALF_WIDTH-1:0]         half_width_b,
	input  logic [HALF_WIDTH-1:0]         half_height_b,
	input  logic [ANGLE_BITS-1:0]         angle_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit
);

	localparam int DEPTH = 9;

	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic             hit_pipe;

	// pipeline advances unless a finished result is blocked while another waits in the last stage
	assign en       = !(vld_q[DEPTH-1] && out_valid && !out_ready);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				vld_q     <= {vld_q[DEPTH-2:0], in_valid};
				out_valid <= vld_q[DEPTH-1] || (out_valid && !out_ready);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[DEPTH-1])
			hit <= hit_pipe;
	end

	trig_t    sa, ca, sb, cb;
	rect_in_t ria_in, rib_in;
	rect_in_t ria [4], rib [4];
	rect_t    ra, rb;

	assign ria_in = '{cx: center_a_x, cy: center_a_y, w: half_width_a, h: half_height_a};
	assign rib_in = '{cx: center_b_x, cy: center_b_y, w: half_width_b, h: half_height_b};

	always_ff @(posedge clk) begin
		if (en) begin
			ria[0] <= ria_in;
			rib[0] <= rib_in;
			for (int i = 1; i < 4; i++) begin
				ria[i] <= ria[i-1];
				rib[i] <= rib[i-1];
			end
		end
	end

	obbt_sincos u_sc_a (.clk, .en, .angle(angle_a), .sin_o(sa), .cos_o(ca));
	obbt_sincos u_sc_b (.clk, .en, .angle(angle_b), .sin_o(sb), .cos_o(cb));

	obbt_corners u_cor_a (.clk, .en, .rin(ria[3]), .s(sa), .c(ca), .rout(ra));
	obbt_corners u_cor_b (.clk, .en, .rin(rib[3]), .s(sb), .c(cb), .rout(rb));

	obbt_sat u_sat (.clk, .en, .ra, .rb, .hit(hit_pipe));

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q)) else $error("pipeline moved during stall");
	a_out_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_feed: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[DEPTH-1] |=> out_valid) else $error("result lost");

endmodule

// File: sim/tb_obb_obb_overlap_test.sv
`timescale 1ns / 100ps

module tb_obb_obb_overlap_test
	import obbt_pkg::*;
();

	typedef struct {
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic [HALF_WIDTH-1:0]         w;
		logic [HALF_WIDTH-1:0]         h;
		logic [ANGLE_BITS-1:0]         ang;
	} box_t;

	typedef struct {
		longint x[4];
		longint y[4];
		longint c;
		longint s;
		bit     has_w;
		bit     has_h;
	} corners_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_WIDTH-1:0] center_a_x = '0, center_a_y = '0;
	logic [HALF_WIDTH-1:0] half_width_a = '0, half_height_a = '0;
	logic [ANGLE_BITS-1:0] angle_a = '0;
	logic signed [COORD_WIDTH-1:0] center_b_x = '0, center_b_y = '0;
	logic [HALF_WIDTH-1:0] half_width_b = '0, half_height_b = '0;
	logic [ANGLE_BITS-1:0] angle_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;

	bit   hit_q[$];
	int   errors = 0;
	longint cycles = 0;
	int   burst_left = 0;
	bit   stall_en = 1'b1;

	obb_obb_overlap_test uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("obb_obb_overlap_test: mismatch");
			$finish;
		end
	end

	function automatic longint quarter_sine(longint x);
		longint x2, t;
		x2 = (x * x) >>> 15;
		t = (2320 * x2) >>> 15;
		t = 21024 - t;
		t = (t * x2) >>> 15;
		t = 51472 - t;
		t = (x * t) >>> 15;
		if (t > 32767)
			t = 32767;
		return t;
	endfunction

	function automatic longint round_half_up(longint v);
		return (v + 16384) >>> 15;
	endfunction

	function automatic corners_t place_box(box_t b);
		corners_t r;
		longint p, q, x, px, py;
		logic [1:0] quad;
		int sx[4] = '{-1, 1, 1, -1};
		int sy[4] = '{-1, -1, 1, 1};
		quad = b.ang[ANGLE_BITS-1 -: 2];
		x = (longint'({b.ang, {(32 - ANGLE_BITS){1'b0}}}) >> 15) & 32'h7fff;
		p = quarter_sine(x);
		q = quarter_sine(32768 - x);
		case (quad)
			2'd0: begin r.s = p; r.c = q; end
			2'd1: begin r.s = q; r.c = -p; end
			2'd2: begin r.s = -p; r.c = -q; end
			default: begin r.s = -q; r.c = p; end
		endcase
		r.has_w = (b.w != 0);
		r.has_h = (b.h != 0);
		for (int i = 0; i < 4; i++) begin
			px = sx[i] * longint'(b.w);
			py = sy[i] * longint'(b.h);
			r.x[i] = longint'(b.cx) + round_half_up(px * r.c - py * r.s);
			r.y[i] = longint'(b.cy) + round_half_up(px * r.s + py * r.c);
		end
		return r;
	endfunction

	function automatic bit axis_separates(corners_t a, corners_t b, longint ax, longint ay);
		longint alo, ahi, blo, bhi, v;
		alo = a.x[0] * ax + a.y[0] * ay; ahi = alo;
		blo = b.x[0] * ax + b.y[0] * ay; bhi = blo;
		for (int i = 1; i < 4; i++) begin
			v = a.x[i] * ax + a.y[i] * ay;
			if (v < alo) alo = v;
			if (v > ahi) ahi = v;
			v = b.x[i] * ax + b.y[i] * ay;
			if (v < blo) blo = v;
			if (v > bhi) bhi = v;
		end
		return (ahi < blo) || (bhi < alo);
	endfunction

	function automatic bit boxes_overlap(box_t a, box_t b);
		corners_t r[2];
		bit res;
		r[0] = place_box(a);
		r[1] = place_box(b);
		res = 1'b1;
		for (int i = 0; i < 2; i++) begin
			if (r[i].has_w && axis_separates(r[0], r[1], r[i].c, r[i].s))
				res = 1'b0;
			if (r[i].has_h && axis_separates(r[0], r[1], -r[i].s, r[i].c))
				res = 1'b0;
		end
		return res;
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		if (!stall_en)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hit_q.size() == 0) begin
				$display("%0t: unexpected transaction, actual hit=%0b", $time, hit);
				errors++;
			end else begin
				if (hit !== hit_q[0]) begin
					$display("%0t: hit expected %0b actual %0b", $time, hit_q[0], hit);
					errors++;
				end
				void'(hit_q.pop_front());
			end
		end
	end

	task automatic send_pair(box_t a, box_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		center_a_x <= a.cx; center_a_y <= a.cy;
		half_width_a <= a.w; half_height_a <= a.h; angle_a <= a.ang;
		center_b_x <= b.cx; center_b_y <= b.cy;
		half_width_b <= b.w; half_height_b <= b.h; angle_b <= b.ang;
		in_valid <= 1'b1;
		hit_q.push_back(boxes_overlap(a, b));
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic box_t rand_box(int span, int sz);
		box_t b;
		b.cx = COORD_WIDTH'($signed($urandom_range(0, 2 * span)) - span);
		b.cy = COORD_WIDTH'($signed($urandom_range(0, 2 * span)) - span);
		b.w = HALF_WIDTH'($urandom_range(0, sz));
		b.h = HALF_WIDTH'($urandom_range(0, sz));
		b.ang = ANGLE_BITS'($urandom);
		return b;
	endfunction

	function automatic box_t full_box();
		box_t b;
		b.cx = COORD_WIDTH'($urandom); b.cy = COORD_WIDTH'($urandom);
		b.w = HALF_WIDTH'($urandom); b.h = HALF_WIDTH'($urandom);
		b.ang = ANGLE_BITS'($urandom);
		return b;
	endfunction

	task automatic test_directed();
		box_t a, b;
		a = '{cx: 0, cy: 0, w: 256, h: 256, ang: 0};
		b = a;
		send_pair(a, b);
		b.cx = 512;
		send_pair(a, b);
		b.cx = 513;
		send_pair(a, b);
		b.ang = 16'h2000;
		send_pair(a, b);
		a.w = 0;
		send_pair(a, b);
		a.h = 0; b.w = 0; b.h = 0;
		send_pair(a, b);
		b.cx = 0;
		send_pair(a, b);
		a = '{cx: {1'b1, {(COORD_WIDTH-1){1'b0}}}, cy: {1'b1, {(COORD_WIDTH-1){1'b0}}},
			w: '1, h: '1, ang: '1};
		b = '{cx: {1'b0, {(COORD_WIDTH-1){1'b1}}}, cy: {1'b0, {(COORD_WIDTH-1){1'b1}}},
			w: '1, h: '1, ang: 16'h8000};
		send_pair(a, b);
		send_pair(b, a);
		a.w = 0; a.h = 0;
		send_pair(a, b);
		for (int q = 0; q < 4; q++) begin
			a = '{cx: 0, cy: 0, w: 1000, h: 300, ang: 16'(q * 16'h4000 + 16'h0555)};
			b = '{cx: 900, cy: 700, w: 500, h: 40, ang: 16'(q * 16'h4000 + 16'h3fff)};
			send_pair(a, b);
		end
		a = '{cx: 0, cy: 0, w: '1, h: 0, ang: 16'h4000};
		b = '{cx: -1, cy: 1, w: 0, h: '1, ang: 16'hc000};
		send_pair(a, b);
	endtask

	task automatic test_random();
		for (int i = 0; i < 600; i++) begin
			case ($urandom_range(0, 9))
				0, 1: send_pair(full_box(), full_box());
				2: send_pair(rand_box(4000, 3), rand_box(4000, 3));
				default: send_pair(rand_box(20000, 8000), rand_box(20000, 8000));
			endcase
			if (i == 300)
				stall_en = 1'b0;
			if (i == 400)
				stall_en = 1'b1;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (hit_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		drain();
		if (errors == 0)
			$display("obb_obb_overlap_test: match");
		else
			$display("obb_obb_overlap_test: mismatch");
		$finish;
	end

endmodule
